[hw/rtl/otr_pkg.sv]
package otr_pkg;

  parameter int unsigned RING_DEPTH_DEF = 32;

  // opcodes
  localparam logic [1:0] OP_LOG   = 2'd0;
  localparam logic [1:0] OP_SNAP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [63:0]        time_ns;
    logic [22:0]        task_id;
    logic [22:0]        group_id;
    logic [11:0]        cpu_index;
    logic [31:0]        event_kind;
    logic signed [31:0] outcome;
    logic [63:0]        addr_first;
    logic [63:0]        addr_second;
    logic [63:0]        addr_third;
    logic [7:0]         max_wanted;
  } in_item_t;

  typedef struct packed {
    logic               is_record;
    logic               last;
    logic [63:0]        sequence_res;
    logic [63:0]        stamp;
    logic [22:0]        process;
    logic [22:0]        process_group;
    logic [11:0]        core;
    logic [31:0]        kind;
    logic signed [31:0] status_code;
    logic [63:0]        word_a;
    logic [63:0]        word_b;
    logic [63:0]        word_c;
  } out_item_t;

  // one ring entry
  typedef struct packed {
    logic [63:0] seq;
    logic [63:0] stamp;
    logic [22:0] process;
    logic [22:0] group;
    logic [11:0] core;
    logic [31:0] kind;
    logic [31:0] status;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic log;
    logic snap_start;
    logic clear;
    logic rd_issue;
    logic load_rec;
    logic load_sum;
  } cmd_t;

  typedef struct packed {
    logic snap_empty;
    logic remain_zero;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/otr_ctrl.sv]
module otr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        opcode_i,
  input  otr_pkg::status_t  status_i,
  output logic              in_stall_o,
  output otr_pkg::cmd_t     cmd_o
);
  import otr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (opcode_i)
            OP_LOG: begin
              cmd_o.log = 1'b1;
            end
            OP_SNAP: begin
              cmd_o.snap_start = 1'b1;
              state_d = status_i.snap_empty ? ST_SUM : ST_READ;
            end
            OP_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_rec = 1'b1;
          state_d = status_i.remain_zero ? ST_SUM : ST_READ;
        end
      end
      ST_SUM: begin
        if (status_i.out_free) begin
          cmd_o.load_sum = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/otr_dp.sv]
module otr_dp #(
  parameter int unsigned RING_DEPTH = otr_pkg::RING_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  otr_pkg::in_item_t  in_item_i,
  input  otr_pkg::cmd_t      cmd_i,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               out_stall_i,
  output otr_pkg::status_t   status_o,
  output logic               out_valid_o,
  output otr_pkg::out_item_t out_item_o
);
  import otr_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
  localparam logic [7:0]    DEPTH_W  = 8'(RING_DEPTH);
  localparam logic [PW:0]   DEPTH_P  = (PW + 1)'(RING_DEPTH);

  rec_t          mem_q [RING_DEPTH];
  rec_t          rdata_q;
  logic          enable_q;
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q, snap_cnt_q, remain_q;
  logic [63:0]   seq_q, dropped_q;
  logic          out_valid_q;
  out_item_t     out_q;

  logic          full;
  logic          log_we;
  logic          out_free;
  logic [7:0]    want_clamp, snap_min;
  logic [CW-1:0] snap_cnt;
  logic [PW:0]   wptr_ext, cnt_ext;
  logic [PW-1:0] snap_start;
  rec_t          wrec;

  assign full     = (cnt_q == DEPTH_C);
  assign log_we   = cmd_i.log && enable_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // snapshot length and first entry
  always_comb begin
    want_clamp = (in_item_i.max_wanted > DEPTH_W) ? DEPTH_W : in_item_i.max_wanted;
    snap_min   = (want_clamp < 8'(cnt_q)) ? want_clamp : 8'(cnt_q);
    snap_cnt   = CW'(snap_min);
    wptr_ext   = {1'b0, wptr_q};
    cnt_ext    = (PW + 1)'(snap_cnt);
    if (wptr_ext >= cnt_ext) begin
      snap_start = PW'(wptr_ext - cnt_ext);
    end else begin
      snap_start = PW'(wptr_ext + DEPTH_P - cnt_ext);
    end
  end

  always_comb begin
    wrec.seq    = seq_q;
    wrec.stamp  = in_item_i.time_ns;
    wrec.process = in_item_i.task_id;
    wrec.group  = in_item_i.group_id;
    wrec.core   = in_item_i.cpu_index;
    wrec.kind   = in_item_i.event_kind;
    wrec.status = in_item_i.outcome;
    wrec.word_a = in_item_i.addr_first;
    wrec.word_b = in_item_i.addr_second;
    wrec.word_c = in_item_i.addr_third;
  end

  // ring storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (log_we) begin
      mem_q[wptr_q] <= wrec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[rptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      cnt_q      <= '0;
      snap_cnt_q <= '0;
      remain_q   <= '0;
      seq_q      <= '0;
      dropped_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        wptr_q    <= '0;
        cnt_q     <= '0;
        seq_q     <= '0;
        dropped_q <= '0;
      end else if (log_we) begin
        seq_q  <= seq_q + 64'd1;
        wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + PW'(1);
        if (full) begin
          dropped_q <= dropped_q + 64'd1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.snap_start) begin
        snap_cnt_q <= snap_cnt;
        remain_q   <= snap_cnt;
        rptr_q     <= snap_start;
      end else if (cmd_i.rd_issue) begin
        remain_q <= remain_q - CW'(1);
        rptr_q   <= (rptr_q == LAST_IDX) ? '0 : rptr_q + PW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_rec || cmd_i.load_sum) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rec) begin
      out_q.is_record     <= 1'b1;
      out_q.last          <= 1'b0;
      out_q.sequence_res  <= rdata_q.seq;
      out_q.stamp         <= rdata_q.stamp;
      out_q.process       <= rdata_q.process;
      out_q.process_group <= rdata_q.group;
      out_q.core          <= rdata_q.core;
      out_q.kind          <= rdata_q.kind;
      out_q.status_code   <= rdata_q.status;
      out_q.word_a        <= rdata_q.word_a;
      out_q.word_b        <= rdata_q.word_b;
      out_q.word_c        <= rdata_q.word_c;
    end else if (cmd_i.load_sum) begin
      out_q.is_record     <= 1'b0;
      out_q.last          <= 1'b1;
      out_q.sequence_res  <= seq_q;
      out_q.stamp         <= '0;
      out_q.process       <= '0;
      out_q.process_group <= '0;
      out_q.core          <= '0;
      out_q.kind          <= '0;
      out_q.status_code   <= '0;
      out_q.word_a        <= dropped_q;
      out_q.word_b        <= 64'(snap_cnt_q);
      out_q.word_c        <= '0;
    end
  end

  assign status_o.snap_empty  = (snap_cnt == '0);
  assign status_o.remain_zero = (remain_q == '0);
  assign status_o.out_free    = out_free;
  assign out_valid_o          = out_valid_q;
  assign out_item_o           = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("stored count above ring depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_rec || cmd_i.load_sum) |-> out_free)
    else $error("pending result overwritten");

  a_log_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (log_we && !cmd_i.clear && !full) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("stored count did not grow on log");

  a_sum_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_sum |=> (out_valid_q && !out_q.is_record && out_q.last))
    else $error("summary item malformed");

endmodule

[hw/rtl/overwriting_event_trace_ring.sv]
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | in_item_i  (otr_pkg::in_item_t)
// out     | output    | out_valid_o/out_stall_i | out_item_o (otr_pkg::out_item_t)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (enable_logging)
//
// Log and clear items can follow each other every cycle while no snapshot runs.
// A snapshot sends each record through the registered read port of the ring and
// then the output register, and ends with a summary item; output stalls hold it.
// rst_ni is asynchronous, active low; it clears pointers, counters, the enable
// and the output valid. The ring itself is not cleared and holds no valid bits.
// in_stall_o is high while a snapshot runs; out_stall_i holds the output register.
module overwriting_event_trace_ring #(
  parameter int unsigned RING_DEPTH = otr_pkg::RING_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  otr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output otr_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import otr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // config register is always writable; the sender must write it only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  // sequencer: accepts items, steps a snapshot through read, load and summary
  otr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_item_i.opcode),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // ring memory, pointers, counters and the output register
  otr_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
